/* hw/rtl/a7dp_pkg.sv */
// Shared types, Adam7 pass tables and helper functions for the deinterlace placer.
`default_nettype none

package a7dp_pkg;

  localparam int unsigned PASS_COUNT = 7;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned PIX_W      = 64;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CFG_IDX_W  = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIB_MODE     = 3'd4;

  // Pixel format codes
  localparam logic [1:0] FMT_GRAY = 2'd0;
  localparam logic [1:0] FMT_RGB  = 2'd1;
  localparam logic [1:0] FMT_RGBA = 2'd2;

  // Adam7 start offsets and log2 of the steps
  localparam logic [2:0] COL_START [PASS_COUNT] = '{3'd0, 3'd4, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0};
  localparam logic [2:0] ROW_START [PASS_COUNT] = '{3'd0, 3'd0, 3'd4, 3'd0, 3'd2, 3'd0, 3'd1};
  localparam logic [1:0] ROW_SHIFT [PASS_COUNT] = '{2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1};
  localparam logic [1:0] COL_SHIFT [PASS_COUNT] = '{2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0};

  typedef logic [SIZE_W-1:0] size_t;

  typedef struct packed {
    logic [PASS_COUNT-1:0]             filled;
    logic [PASS_COUNT-1:0][SIZE_W-1:0] cols;
    logic [PASS_COUNT-1:0][SIZE_W-1:0] rows;
    logic [SIZE_W-1:0]                 height;
    logic [2:0]                        first;
    logic                              any;
  } geom_t;

  // Lowest filled pass strictly above p; MSB flags a hit.
  function automatic logic [3:0] next_after(input logic [PASS_COUNT-1:0] filled,
                                            input logic [2:0] p);
    logic [3:0] res;
    res = 4'd0;
    for (int i = PASS_COUNT - 1; i >= 0; i--) begin
      if ((3'(i) > p) && filled[i]) begin
        res = {1'b1, 3'(i)};
      end
    end
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] byte_mask(input logic [3:0] n);
    logic [PIX_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < n) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  function automatic logic [PIX_W-1:0] shape_pixel(input logic [PIX_W-1:0] v,
                                                   input logic [1:0] fmt,
                                                   input logic [3:0] bpp,
                                                   input logic dib);
    logic [PIX_W-1:0] r;
    case (fmt) inside
      FMT_RGB, FMT_RGBA: begin
        r = v & byte_mask((fmt == FMT_RGB) ? 4'd3 : 4'd4);
        if (dib) begin
          r = {r[63:24], r[7:0], r[15:8], r[23:16]};
        end
      end
      default: begin
        r = v & byte_mask(bpp);
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/adam7_deinterlace_placer_top.sv */
// Top level of the Adam7 deinterlace placer: position tracking and output register.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | input     | in_valid_i/in_ready_o   | pixel_in_i
//  out     | output    | out_valid_o/out_ready_i | dest_column_o dest_row_o pixel_out_o
//          |           |                         | pass_index_o last_of_image_o
//  cfg     | input     | cfg_we_i                | cfg_index_i cfg_data_i
//
//  One pixel per clock while in_ready_o is high; a result appears the cycle after its input transfer.
//  The output register holds each result; the pass/row/column counters give its position.
//  Reset and any register write restart at the first non-empty pass, row 0, column 0.
//  in_ready_o is high while the output register is empty or being drained.
//  A pixel taken while the image is empty is dropped without a result.
`default_nettype none

module adam7_deinterlace_placer_top import a7dp_pkg::*; #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [PIX_W-1:0]     pixel_in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [POS_W-1:0]          dest_column_o,
  output logic [POS_W-1:0]          dest_row_o,
  output logic [PIX_W-1:0]          pixel_out_o,
  output logic [2:0]                pass_index_o,
  output logic                      last_of_image_o
);

  logic [SIZE_W-1:0] width_q, height_q;
  logic [3:0]        bpp_q;
  logic [1:0]        fmt_q;
  logic              dib_q;
  logic              cfg_hit;

  logic [2:0]        pass_q, pass_d;
  logic [POS_W-1:0]  row_q, row_d, col_q, col_d;

  logic              out_valid_q;
  logic [POS_W-1:0]  dcol_q, drow_q;
  logic [PIX_W-1:0]  pix_q;
  logic [2:0]        opass_q;
  logic              last_q;

  geom_t             geom;
  logic              pass_ok, in_xfer, emit;
  logic [2:0]        p;
  logic [SIZE_W-1:0] cols, rows, col_inc, row_inc;
  logic [POS_W-1:0]  colc, rowc, dcol, drow_raw, drow;
  logic              col_wrap, row_wrap, last;
  logic [3:0]        nxt;

  a7dp_pass_geom #(
    .MAX_SIDE(MAX_SIDE)
  ) u_geom (
    .width_i (width_q),
    .height_i(height_q),
    .geom_o  (geom)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign emit       = in_xfer && geom.any;

  always_comb begin
    unique case (cfg_index_i) inside
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_BYTES_PER_PX,
      REG_PIXEL_FORMAT, REG_DIB_MODE: cfg_hit = cfg_we_i;
      default:                        cfg_hit = 1'b0;
    endcase
  end

  always_comb begin
    // Fall back to the first filled pass when the held pass is empty
    pass_ok  = geom.filled[pass_q];
    p        = pass_ok ? pass_q : geom.first;
    cols     = geom.cols[p];
    rows     = geom.rows[p];
    colc     = (pass_ok && ({1'b0, col_q} < cols)) ? col_q : '0;
    rowc     = (pass_ok && ({1'b0, row_q} < rows)) ? row_q : '0;
    col_inc  = {1'b0, colc} + SIZE_W'(1);
    row_inc  = {1'b0, rowc} + SIZE_W'(1);
    col_wrap = col_inc >= cols;
    row_wrap = row_inc >= rows;
    nxt      = next_after(geom.filled, p);
    last     = col_wrap && row_wrap && !nxt[3];

    dcol     = POS_W'(COL_START[p]) + (colc << COL_SHIFT[p]);
    drow_raw = POS_W'(ROW_START[p]) + (rowc << ROW_SHIFT[p]);
    drow     = dib_q ? (geom.height[POS_W-1:0] - POS_W'(1) - drow_raw) : drow_raw;

    col_d  = col_wrap ? '0 : col_inc[POS_W-1:0];
    row_d  = rowc;
    pass_d = p;
    if (col_wrap) begin
      row_d = row_wrap ? '0 : row_inc[POS_W-1:0];
      if (row_wrap) begin
        pass_d = nxt[3] ? nxt[2:0] : geom.first;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(1);
      height_q <= SIZE_W'(1);
      bpp_q    <= 4'd1;
      fmt_q    <= FMT_GRAY;
      dib_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        REG_BYTES_PER_PX: bpp_q    <= cfg_data_i[3:0];
        REG_PIXEL_FORMAT: fmt_q    <= cfg_data_i[1:0];
        REG_DIB_MODE:     dib_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Position counters; pass 0 on restart resolves to the first filled pass at use
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= 3'd0;
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_hit) begin
      pass_q <= 3'd0;
      row_q  <= '0;
      col_q  <= '0;
    end else if (emit) begin
      pass_q <= pass_d;
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      dcol_q  <= dcol;
      drow_q  <= drow;
      pix_q   <= shape_pixel(pixel_in_i, fmt_q, bpp_q, dib_q);
      opass_q <= p;
      last_q  <= last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign dest_column_o   = dcol_q;
  assign dest_row_o      = drow_q;
  assign pixel_out_o     = pix_q;
  assign pass_index_o    = opass_q;
  assign last_of_image_o = last_q;

  a_pass_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_q <= 3'd6)
    else $error("pass counter out of range");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (pass_q == 3'd0) && (row_q == '0) && (col_q == '0))
    else $error("register write did not restart position");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last && !cfg_hit) |=> (row_q == '0) && (col_q == '0) && (pass_q == $past(geom.first)))
    else $error("position not wrapped after last pixel");

  a_emit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o)
    else $error("transfer with filled image produced no result");

endmodule

`default_nettype wire

/* hw/rtl/a7dp_pass_geom.sv */
// Per-pass column/row counts and occupancy derived from the image size.
`default_nettype none

module a7dp_pass_geom import a7dp_pkg::*; #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  wire logic [SIZE_W-1:0] width_i,
  input  wire logic [SIZE_W-1:0] height_i,
  output geom_t                  geom_o
);

  localparam int unsigned SideLimit = (MAX_SIDE > 8191) ? 8191 : MAX_SIDE;
  localparam logic [SIZE_W-1:0] SideMax = SIZE_W'(SideLimit);

  size_t w_clamp, h_clamp;

  function automatic size_t span(input size_t sz, input logic [2:0] start,
                                 input logic [1:0] sh);
    logic [SIZE_W:0] num;
    logic [SIZE_W:0] bias;
    bias = (SIZE_W + 1)'((1 << sh) - 1);
    num  = {1'b0, sz} - {11'd0, start} + bias;
    if (sz <= {10'd0, start}) begin
      return '0;
    end
    return SIZE_W'(num >> sh);
  endfunction

  always_comb begin
    w_clamp = (width_i > SideMax) ? SideMax : width_i;
    h_clamp = (height_i > SideMax) ? SideMax : height_i;
    geom_o.height = h_clamp;
    for (int p = 0; p < PASS_COUNT; p++) begin
      geom_o.cols[p]   = span(w_clamp, COL_START[p], COL_SHIFT[p]);
      geom_o.rows[p]   = span(h_clamp, ROW_START[p], ROW_SHIFT[p]);
      geom_o.filled[p] = (geom_o.cols[p] != '0) && (geom_o.rows[p] != '0);
    end
    geom_o.any   = |geom_o.filled;
    geom_o.first = 3'd0;
    for (int p = PASS_COUNT - 1; p >= 0; p--) begin
      if (geom_o.filled[p]) begin
        geom_o.first = 3'(p);
      end
    end
  end

endmodule

`default_nettype wire
